// ----- rtl/core/tscd_pkg.sv -----
package tscd_pkg;

   typedef logic [2:0] cat_type;

   typedef struct packed {
      logic step;
      logic clear;
   } dbn_ctl_type;

   typedef enum logic [2:0] {
      CSR_TEMP_ENABLE   = 3'd0,
      CSR_LIGHT_ENABLE  = 3'd1,
      CSR_NOISE_ENABLE  = 3'd2,
      CSR_FORCE_COLD    = 3'd3,
      CSR_TEMP_CONFIRM  = 3'd4,
      CSR_NOISE_CONFIRM = 3'd5,
      CSR_LIGHT_CONFIRM = 3'd6
   } csr_index_type;

   localparam logic [2:0] LOCK_ALL   = 3'd0;
   localparam logic [2:0] LOCK_LIGHT = 3'd1;
   localparam logic [2:0] LOCK_TEMP  = 3'd2;
   localparam logic [2:0] LOCK_NOISE = 3'd3;

   localparam logic signed [11:0] TEMP_SUBST_TENTHS  = 12'sd250;
   localparam logic signed [20:0] LIGHT_SUBST_TENTHS = 21'sd2500;
   localparam logic [10:0]        NOISE_SUBST_TENTHS = 11'd550;
   localparam logic signed [11:0] COLD_TENTHS        = 12'sd100;

   localparam cat_type TEMP_RST_CAT  = 3'd3;
   localparam cat_type NOISE_RST_CAT = 3'd3;
   localparam cat_type LIGHT_RST_CAT = 3'd2;

   localparam logic [2:0] TEMP_CONFIRM_RST  = 3'd2;
   localparam logic [2:0] NOISE_CONFIRM_RST = 3'd5;
   localparam logic [2:0] LIGHT_CONFIRM_RST = 3'd2;

   // ceil(2^24 / 10); exact floor(x / 10) for every x below 2^22
   localparam logic [20:0] DIV10_MULT = 21'd1677722;

   function automatic logic [18:0] div10(input logic [21:0] x);
      logic [42:0] prod;
      prod = {21'd0, x} * {22'd0, DIV10_MULT};
      return prod[42:24];
   endfunction

   function automatic cat_type temp_cat(input logic [7:0] t);
      if (t >= 8'd31)      return 3'd1;
      else if (t >= 8'd28) return 3'd2;
      else if (t >= 8'd22) return 3'd3;
      else if (t >= 8'd16) return 3'd4;
      else                 return 3'd5;
   endfunction

   function automatic cat_type light_cat(input logic [16:0] l);
      if (l >= 17'd700)      return 3'd1;
      else if (l >= 17'd150) return 3'd2;
      else if (l >= 17'd50)  return 3'd3;
      else                   return 3'd4;
   endfunction

   function automatic cat_type noise_cat(input logic [7:0] n);
      if (n >= 8'd80)      return 3'd1;
      else if (n >= 8'd65) return 3'd2;
      else if (n >= 8'd50) return 3'd3;
      else                 return 3'd4;
   endfunction

endpackage

// ----- rtl/core/tscd_debounce.sv -----
module tscd_debounce (
   input  logic                  clock,
   input  logic                  reset,
   input  tscd_pkg::dbn_ctl_type ctl,
   input  tscd_pkg::cat_type     cur,
   input  logic [2:0]            need,
   input  tscd_pkg::cat_type     rst_cat,
   output tscd_pkg::cat_type     stable,
   output tscd_pkg::cat_type     stable_next,
   output logic                  hit
);
   import tscd_pkg::*;

   cat_type    stable_ff, stable_in;
   cat_type    pending_ff, pending_in;
   logic [2:0] count_ff, count_in;
   logic [2:0] count_inc;

   always_comb begin
      stable_in  = stable_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      count_inc  = count_ff + 3'd1;
      hit        = 1'b0;
      if (ctl.clear) begin
         stable_in  = rst_cat;
         pending_in = rst_cat;
         count_in   = 3'd0;
      end else if (ctl.step) begin
         if (cur == stable_ff) begin
            pending_in = stable_ff;
            count_in   = 3'd0;
         end else if (cur == pending_ff) begin
            if (count_inc >= need) begin
               stable_in = cur;
               count_in  = 3'd0;
               hit       = 1'b1;
            end else begin
               count_in = count_inc;
            end
         end else begin
            pending_in = cur;
            count_in   = 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff  <= rst_cat;
         pending_ff <= rst_cat;
         count_ff   <= 3'd0;
      end else begin
         stable_ff  <= stable_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

   assign stable      = stable_ff;
   assign stable_next = stable_in;

endmodule

// ----- rtl/core/three_sensor_category_debouncer.sv -----
// Three-sensor category debouncer.
// req_* channel: one sample tick per beat (temperature, light, noise in tenths,
// NaN flags, lock selector, restart). rsp_* channel: one result beat per tick
// with the confirmation event, drop flag, rounded values and stable categories.
// csr_* port: plain register writes, which the user makes only while no tick is
// in flight; the block does not enforce it. A tick passes the input and then
// the result register to rsp_*. Throughput: one tick per cycle unless rsp_stall
// holds a result; debouncer state and result register load in the same cycle.
// Stall: when rsp_stall holds a waiting result, the input register still takes
// one more beat; req_stall rises only when both registers are full, and it
// follows rsp_stall combinationally.
// Reset: clears both registers, loads the register defaults (all channels
// enabled, no force cold, confirm counts 2/5/2) and the debouncer state
// (temperature cool, noise normal, light bright). A restart beat does the same
// to the debouncer state only and returns a dropped result.
module three_sensor_category_debouncer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_restart,
   input  logic [2:0]               req_lock_sel,
   input  logic signed [11:0]       req_temp_tenths,
   input  logic                     req_temp_ok,
   input  logic signed [20:0]       req_light_tenths,
   input  logic                     req_light_ok,
   input  logic [10:0]              req_noise_tenths,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_event_res,
   output logic                     rsp_dropped,
   output logic [6:0]               rsp_temp_whole,
   output logic [15:0]              rsp_light_whole,
   output logic [7:0]               rsp_noise_whole,
   output tscd_pkg::cat_type        rsp_stable_temp_cat,
   output tscd_pkg::cat_type        rsp_stable_light_cat,
   output tscd_pkg::cat_type        rsp_stable_noise_cat,
   input  logic                     csr_we,
   input  logic [2:0]               csr_index,
   input  logic [2:0]               csr_wdata
);
   import tscd_pkg::*;

   // configuration
   logic       temp_enable_ff, light_enable_ff, noise_enable_ff, force_cold_ff;
   logic [2:0] temp_confirm_ff, noise_confirm_ff, light_confirm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_enable_ff   <= 1'b1;
         light_enable_ff  <= 1'b1;
         noise_enable_ff  <= 1'b1;
         force_cold_ff    <= 1'b0;
         temp_confirm_ff  <= TEMP_CONFIRM_RST;
         noise_confirm_ff <= NOISE_CONFIRM_RST;
         light_confirm_ff <= LIGHT_CONFIRM_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TEMP_ENABLE:   temp_enable_ff   <= csr_wdata[0];
            CSR_LIGHT_ENABLE:  light_enable_ff  <= csr_wdata[0];
            CSR_NOISE_ENABLE:  noise_enable_ff  <= csr_wdata[0];
            CSR_FORCE_COLD:    force_cold_ff    <= csr_wdata[0];
            CSR_TEMP_CONFIRM:  temp_confirm_ff  <= csr_wdata;
            CSR_NOISE_CONFIRM: noise_confirm_ff <= csr_wdata;
            CSR_LIGHT_CONFIRM: light_confirm_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_restart_ff;
   logic [2:0]        s1_lock_ff;
   logic signed [11:0] s1_temp_ff;
   logic              s1_temp_ok_ff;
   logic signed [20:0] s1_light_ff;
   logic              s1_light_ok_ff;
   logic [10:0]       s1_noise_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept, adv;

   assign adv        = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !adv;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept)  s1_valid_in = 1'b1;
      else if (adv)    s1_valid_in = 1'b0;
      else             s1_valid_in = s1_valid_ff;
      if (adv)             rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_restart_ff  <= req_restart;
         s1_lock_ff     <= req_lock_sel;
         s1_temp_ff     <= req_temp_tenths;
         s1_temp_ok_ff  <= req_temp_ok;
         s1_light_ff    <= req_light_tenths;
         s1_light_ok_ff <= req_light_ok;
         s1_noise_ff    <= req_noise_tenths;
      end
   end

   // substitution, validity, rounding, categories
   logic signed [11:0] t_val;
   logic               t_good;
   logic signed [20:0] l_val;
   logic               l_good;
   logic [10:0]        n_val;
   logic               drop;
   logic [18:0]        tw_q, lw_q, nw_q;
   logic [7:0]         tw;
   logic [16:0]        lw;
   logic [7:0]         nw;
   logic [6:0]         tw_sat;
   logic [15:0]        lw_sat;
   cat_type            tc, lc, nc;
   logic               mon_light, mon_temp, mon_noise;

   always_comb begin
      t_val  = s1_temp_ff;
      t_good = s1_temp_ok_ff;
      if (!temp_enable_ff) begin
         t_val  = TEMP_SUBST_TENTHS;
         t_good = 1'b1;
      end
      if (force_cold_ff) begin
         t_val  = COLD_TENTHS;
         t_good = 1'b1;
      end
      l_val  = light_enable_ff ? s1_light_ff : LIGHT_SUBST_TENTHS;
      l_good = light_enable_ff ? s1_light_ok_ff : 1'b1;
      n_val  = noise_enable_ff ? s1_noise_ff : NOISE_SUBST_TENTHS;

      drop = !t_good || t_val[11] || (t_val == 12'sd0) || !l_good || l_val[20];

      // values are non-negative here whenever the tick is kept
      tw_q = div10({10'd0, t_val[11:0]} + 22'd5);
      lw_q = div10({1'b0, l_val[20:0]} + 22'd5);
      nw_q = div10({11'd0, n_val} + 22'd5);
      tw   = tw_q[7:0];
      lw   = lw_q[16:0];
      nw   = nw_q[7:0];

      tw_sat = (tw > 8'd127) ? 7'd127 : tw[6:0];
      lw_sat = lw[16] ? 16'hFFFF : lw[15:0];

      tc = temp_cat(tw);
      lc = light_cat(lw);
      nc = noise_cat(nw);

      mon_light = (s1_lock_ff == LOCK_ALL) || (s1_lock_ff == LOCK_LIGHT);
      mon_temp  = (s1_lock_ff == LOCK_ALL) || (s1_lock_ff == LOCK_TEMP);
      mon_noise = (s1_lock_ff == LOCK_ALL) || (s1_lock_ff == LOCK_NOISE);
   end

   dbn_ctl_type ctl_temp, ctl_light, ctl_noise;
   logic        work;

   assign work = adv && !s1_restart_ff && !drop;

   always_comb begin
      ctl_temp.clear  = adv && s1_restart_ff;
      ctl_light.clear = adv && s1_restart_ff;
      ctl_noise.clear = adv && s1_restart_ff;
      ctl_temp.step   = work && mon_temp;
      ctl_light.step  = work && mon_light;
      ctl_noise.step  = work && mon_noise;
   end

   cat_type temp_stable, light_stable, noise_stable;
   cat_type temp_next, light_next, noise_next;
   logic    temp_hit, light_hit, noise_hit;

   tscd_debounce u_temp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl_temp),
      .cur         (tc),
      .need        (temp_confirm_ff),
      .rst_cat     (TEMP_RST_CAT),
      .stable      (temp_stable),
      .stable_next (temp_next),
      .hit         (temp_hit)
   );

   tscd_debounce u_light (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl_light),
      .cur         (lc),
      .need        (light_confirm_ff),
      .rst_cat     (LIGHT_RST_CAT),
      .stable      (light_stable),
      .stable_next (light_next),
      .hit         (light_hit)
   );

   tscd_debounce u_noise (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl_noise),
      .cur         (nc),
      .need        (noise_confirm_ff),
      .rst_cat     (NOISE_RST_CAT),
      .stable      (noise_stable),
      .stable_next (noise_next),
      .hit         (noise_hit)
   );

   // result register
   logic       event_ff, dropped_ff;
   logic [6:0] temp_whole_ff;
   logic [15:0] light_whole_ff;
   logic [7:0] noise_whole_ff;
   cat_type    temp_cat_ff, light_cat_ff, noise_cat_ff;
   logic       kill;

   assign kill = s1_restart_ff || drop;

   always_ff @(posedge clock) begin
      if (adv) begin
         event_ff       <= temp_hit || light_hit || noise_hit;
         dropped_ff     <= kill;
         temp_whole_ff  <= kill ? 7'd0 : tw_sat;
         light_whole_ff <= kill ? 16'd0 : lw_sat;
         noise_whole_ff <= kill ? 8'd0 : nw;
         temp_cat_ff    <= temp_next;
         light_cat_ff   <= light_next;
         noise_cat_ff   <= noise_next;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_res        = event_ff;
   assign rsp_dropped          = dropped_ff;
   assign rsp_temp_whole       = temp_whole_ff;
   assign rsp_light_whole      = light_whole_ff;
   assign rsp_noise_whole      = noise_whole_ff;
   assign rsp_stable_temp_cat  = temp_cat_ff;
   assign rsp_stable_light_cat = light_cat_ff;
   assign rsp_stable_noise_cat = noise_cat_ff;

`ifndef SYNTH
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && s1_restart_ff) |=> (rsp_dropped && !rsp_event_res &&
         rsp_stable_temp_cat == TEMP_RST_CAT && rsp_stable_light_cat == LIGHT_RST_CAT &&
         rsp_stable_noise_cat == NOISE_RST_CAT))
      else $error("restart beat did not clear debouncer state");

   a_event_not_dropped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res) |-> !rsp_dropped)
      else $error("event raised on a dropped beat");

   a_dropped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |->
         (rsp_temp_whole == 7'd0 && rsp_light_whole == 16'd0 && rsp_noise_whole == 8'd0))
      else $error("dropped beat carries nonzero values");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(temp_stable) && $stable(light_stable) && $stable(noise_stable)))
      else $error("stable category changed without a beat");
`endif

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
   import tscd_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int DRAIN_MARGIN = 4;
   localparam int HOLD_CYCLES = 60;
   localparam logic [2:0] LOCK_NONE = 3'd4;

   localparam int TEMP_FILL_TENTHS  = 250;
   localparam int LIGHT_FILL_TENTHS = 2500;
   localparam int NOISE_FILL_TENTHS = 550;
   localparam int COLD_FORCE_TENTHS = 100;

   localparam cat_type CAT_TEMP_COOL    = 3'd3;
   localparam cat_type CAT_LIGHT_BRIGHT = 3'd2;
   localparam cat_type CAT_NOISE_NORMAL = 3'd3;

   typedef enum int {CH_TEMP, CH_LIGHT, CH_NOISE} channel_type;

   typedef struct {
      logic              restart;
      logic [2:0]        lock_sel;
      logic signed [11:0] temp_tenths;
      logic              temp_ok;
      logic signed [20:0] light_tenths;
      logic              light_ok;
      logic [10:0]       noise_tenths;
   } sensor_tick_type;

   typedef struct {
      logic        event_res;
      logic        dropped;
      logic [6:0]  temp_whole;
      logic [15:0] light_whole;
      logic [7:0]  noise_whole;
      cat_type     temp_cat;
      cat_type     light_cat;
      cat_type     noise_cat;
   } tick_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_restart = 1'b0;
   logic [2:0]         req_lock_sel = '0;
   logic signed [11:0] req_temp_tenths = '0;
   logic               req_temp_ok = 1'b0;
   logic signed [20:0] req_light_tenths = '0;
   logic               req_light_ok = 1'b0;
   logic [10:0]        req_noise_tenths = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_event_res;
   logic               rsp_dropped;
   logic [6:0]         rsp_temp_whole;
   logic [15:0]        rsp_light_whole;
   logic [7:0]         rsp_noise_whole;
   cat_type            rsp_stable_temp_cat;
   cat_type            rsp_stable_light_cat;
   cat_type            rsp_stable_noise_cat;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [2:0]         csr_wdata = '0;

   // register mirror
   logic       cfg_temp_en = 1'b1;
   logic       cfg_light_en = 1'b1;
   logic       cfg_noise_en = 1'b1;
   logic       cfg_force_cold = 1'b0;
   logic [2:0] cfg_temp_confirm = 3'd2;
   logic [2:0] cfg_noise_confirm = 3'd5;
   logic [2:0] cfg_light_confirm = 3'd2;

   // debouncer mirror, one slot per channel
   cat_type    cat_stable [3];
   cat_type    cat_pending [3];
   logic [2:0] match_count [3];

   sensor_tick_type  sensor_ticks [$];
   tick_outcome_type tick_outcomes [$];
   sensor_tick_type  live_tick;

   int outstanding = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int rsp_hold_left = 0;
   bit hold_armed = 1'b0;
   bit hold_taken = 1'b0;

   three_sensor_category_debouncer u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_restart          (req_restart),
      .req_lock_sel         (req_lock_sel),
      .req_temp_tenths      (req_temp_tenths),
      .req_temp_ok          (req_temp_ok),
      .req_light_tenths     (req_light_tenths),
      .req_light_ok         (req_light_ok),
      .req_noise_tenths     (req_noise_tenths),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_res        (rsp_event_res),
      .rsp_dropped          (rsp_dropped),
      .rsp_temp_whole       (rsp_temp_whole),
      .rsp_light_whole      (rsp_light_whole),
      .rsp_noise_whole      (rsp_noise_whole),
      .rsp_stable_temp_cat  (rsp_stable_temp_cat),
      .rsp_stable_light_cat (rsp_stable_light_cat),
      .rsp_stable_noise_cat (rsp_stable_noise_cat),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_debounce();
      cat_stable[CH_TEMP] = CAT_TEMP_COOL;
      cat_pending[CH_TEMP] = CAT_TEMP_COOL;
      cat_stable[CH_LIGHT] = CAT_LIGHT_BRIGHT;
      cat_pending[CH_LIGHT] = CAT_LIGHT_BRIGHT;
      cat_stable[CH_NOISE] = CAT_NOISE_NORMAL;
      cat_pending[CH_NOISE] = CAT_NOISE_NORMAL;
      foreach (match_count[i]) match_count[i] = 3'd0;
   endfunction

   function automatic bit settle_channel(channel_type ch, cat_type seen, logic [2:0] need);
      if (seen == cat_stable[ch]) begin
         cat_pending[ch] = cat_stable[ch];
         match_count[ch] = 3'd0;
         return 1'b0;
      end
      if (seen == cat_pending[ch]) begin
         match_count[ch] = match_count[ch] + 3'd1;
         if (match_count[ch] >= need) begin
            cat_stable[ch] = seen;
            match_count[ch] = 3'd0;
            return 1'b1;
         end
         return 1'b0;
      end
      // new candidate: first sighting, no confirm check
      cat_pending[ch] = seen;
      match_count[ch] = 3'd1;
      return 1'b0;
   endfunction

   function automatic tick_outcome_type predict_tick(sensor_tick_type tk);
      tick_outcome_type o;
      int t, l, n, tw, lw, nw;
      bit t_ok, l_ok, fired;
      cat_type tc, lc, nc;
      t = tk.temp_tenths;
      l = tk.light_tenths;
      n = tk.noise_tenths;
      t_ok = tk.temp_ok;
      l_ok = tk.light_ok;
      fired = 1'b0;
      o.dropped = 1'b0;
      o.temp_whole = '0;
      o.light_whole = '0;
      o.noise_whole = '0;
      if (tk.restart) begin
         clear_debounce();
         o.dropped = 1'b1;
      end else begin
         if (!cfg_temp_en) begin
            t = TEMP_FILL_TENTHS;
            t_ok = 1'b1;
         end
         if (!cfg_light_en) begin
            l = LIGHT_FILL_TENTHS;
            l_ok = 1'b1;
         end
         if (!cfg_noise_en) n = NOISE_FILL_TENTHS;
         if (cfg_force_cold) begin
            t = COLD_FORCE_TENTHS;
            t_ok = 1'b1;
         end
         if (!t_ok || t <= 0 || !l_ok || l < 0) begin
            o.dropped = 1'b1;
         end else begin
            tw = (t + 5) / 10;
            lw = (l + 5) / 10;
            nw = (n + 5) / 10;
            // category grows by one per threshold the value falls below
            tc = cat_type'(1 + (tw < 31) + (tw < 28) + (tw < 22) + (tw < 16));
            lc = cat_type'(1 + (lw < 700) + (lw < 150) + (lw < 50));
            nc = cat_type'(1 + (nw < 80) + (nw < 65) + (nw < 50));
            if (tk.lock_sel == LOCK_ALL || tk.lock_sel == LOCK_LIGHT)
               fired |= settle_channel(CH_LIGHT, lc, cfg_light_confirm);
            if (tk.lock_sel == LOCK_ALL || tk.lock_sel == LOCK_TEMP)
               fired |= settle_channel(CH_TEMP, tc, cfg_temp_confirm);
            if (tk.lock_sel == LOCK_ALL || tk.lock_sel == LOCK_NOISE)
               fired |= settle_channel(CH_NOISE, nc, cfg_noise_confirm);
            o.temp_whole = 7'((tw > 127) ? 127 : tw);
            o.light_whole = 16'((lw > 65535) ? 65535 : lw);
            o.noise_whole = 8'((nw > 255) ? 255 : nw);
         end
      end
      o.event_res = fired;
      o.temp_cat = cat_stable[CH_TEMP];
      o.light_cat = cat_stable[CH_LIGHT];
      o.noise_cat = cat_stable[CH_NOISE];
      return o;
   endfunction

   task automatic flag_error(string msg);
      if (mismatches < 40) $display("%0t: ERROR %s", $time, msg);
      mismatches++;
   endtask

   // four-state compare so an unknown output never slips through
   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) flag_error($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   task automatic queue_tick(logic restart, logic [2:0] lock, int t, logic tok,
                             int l, logic lok, int n);
      sensor_tick_type tk;
      tk.restart = restart;
      tk.lock_sel = lock;
      tk.temp_tenths = t[11:0];
      tk.temp_ok = tok;
      tk.light_tenths = l[20:0];
      tk.light_ok = lok;
      tk.noise_tenths = n[10:0];
      sensor_ticks.push_back(tk);
      outstanding++;
   endtask

   task automatic wait_drained();
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_MARGIN) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [2:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_TEMP_ENABLE:   cfg_temp_en = val[0];
         CSR_LIGHT_ENABLE:  cfg_light_en = val[0];
         CSR_NOISE_ENABLE:  cfg_noise_en = val[0];
         CSR_FORCE_COLD:    cfg_force_cold = val[0];
         CSR_TEMP_CONFIRM:  cfg_temp_confirm = val;
         CSR_NOISE_CONFIRM: cfg_noise_confirm = val;
         CSR_LIGHT_CONFIRM: cfg_light_confirm = val;
         default: ;
      endcase
   endtask

   task automatic apply_setting(logic te, logic le, logic ne, logic fc,
                                logic [2:0] tcf, logic [2:0] ncf, logic [2:0] lcf);
      write_reg(CSR_TEMP_ENABLE, {2'b0, te});
      write_reg(CSR_LIGHT_ENABLE, {2'b0, le});
      write_reg(CSR_NOISE_ENABLE, {2'b0, ne});
      write_reg(CSR_FORCE_COLD, {2'b0, fc});
      write_reg(CSR_TEMP_CONFIRM, tcf);
      write_reg(CSR_NOISE_CONFIRM, ncf);
      write_reg(CSR_LIGHT_CONFIRM, lcf);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly runs of ticks that hold each channel in one band so the debouncers
   // reach their confirm counts; the rest is raw noise on every bit.
   task automatic queue_random_ticks(int count);
      int made, run_len, t_band, l_band, n_band, r, t, l, n;
      logic [2:0] lock;
      made = 0;
      while (made < count) begin
         if ($urandom_range(9) == 0) begin
            queue_tick($urandom_range(19) == 0, 3'($urandom_range(7)),
                       $urandom_range(4095), 1'($urandom_range(1)),
                       $urandom_range(2097151), 1'($urandom_range(1)),
                       $urandom_range(2047));
            made++;
         end else begin
            r = $urandom_range(15);
            if (r < 8) lock = LOCK_ALL;
            else if (r < 10) lock = LOCK_LIGHT;
            else if (r < 12) lock = LOCK_TEMP;
            else if (r < 14) lock = LOCK_NOISE;
            else if (r == 14) lock = LOCK_NONE;
            else lock = 3'($urandom_range(7, 5));
            t_band = ($urandom_range(19) == 0) ? 5 : $urandom_range(4);
            l_band = ($urandom_range(19) == 0) ? 4 : $urandom_range(3);
            n_band = ($urandom_range(19) == 0) ? 4 : $urandom_range(3);
            run_len = $urandom_range(10, 1);
            for (int i = 0; i < run_len; i++) begin
               case (t_band)
                  0: t = $urandom_range(1250, 305);
                  1: t = $urandom_range(304, 275);
                  2: t = $urandom_range(274, 215);
                  3: t = $urandom_range(214, 155);
                  4: t = $urandom_range(154, 1);
                  default: t = $urandom_range(2047, 1251);
               endcase
               case (l_band)
                  0: l = $urandom_range(655350, 6995);
                  1: l = $urandom_range(6994, 1495);
                  2: l = $urandom_range(1494, 495);
                  3: l = $urandom_range(494, 0);
                  default: l = $urandom_range(1048575, 655351);
               endcase
               case (n_band)
                  0: n = $urandom_range(1300, 795);
                  1: n = $urandom_range(794, 645);
                  2: n = $urandom_range(644, 495);
                  3: n = $urandom_range(494, 0);
                  default: n = $urandom_range(2047, 1301);
               endcase
               queue_tick(1'b0, lock, t, 1'b1, l, 1'b1, n);
               made++;
            end
         end
      end
   endtask

   // sender: a beat leaves only when accepted or when nothing is offered
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) tick_outcomes.push_back(predict_tick(live_tick));
         if (!req_valid || !req_stall) begin
            if (sensor_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               live_tick = sensor_ticks.pop_front();
               req_restart <= live_tick.restart;
               req_lock_sel <= live_tick.lock_sel;
               req_temp_tenths <= live_tick.temp_tenths;
               req_temp_ok <= live_tick.temp_ok;
               req_light_tenths <= live_tick.light_tenths;
               req_light_ok <= live_tick.light_ok;
               req_noise_tenths <= live_tick.noise_tenths;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (hold_armed && !hold_taken) begin
         // one long hold-off, counted down here
         rsp_stall <= 1'b1;
         rsp_hold_left <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : result_check
      tick_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tick_outcomes.size() == 0) begin
            flag_error("result beat with no tick outstanding");
         end else begin
            want = tick_outcomes.pop_front();
            check_field("event_res", rsp_event_res, want.event_res);
            check_field("dropped", rsp_dropped, want.dropped);
            check_field("temp_whole", rsp_temp_whole, want.temp_whole);
            check_field("light_whole", rsp_light_whole, want.light_whole);
            check_field("noise_whole", rsp_noise_whole, want.noise_whole);
            check_field("stable_temp_cat", rsp_stable_temp_cat, want.temp_cat);
            check_field("stable_light_cat", rsp_stable_light_cat, want.light_cat);
            check_field("stable_noise_cat", rsp_stable_noise_cat, want.noise_cat);
            outstanding--;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("three_sensor_category_debouncer verification failed");
      $finish;
   end

   initial begin
      clear_debounce();
      send_idle_pct = 11;
      recv_idle_pct = 52;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed ticks on reset settings
      queue_tick(1'b1, LOCK_ALL, 0, 1'b0, 0, 1'b0, 0);
      queue_tick(1'b0, LOCK_ALL, 315, 1'b1, 7000, 1'b1, 800);
      queue_tick(1'b0, LOCK_ALL, 315, 1'b1, 7000, 1'b1, 800);
      queue_tick(1'b0, LOCK_ALL, 1250, 1'b1, 655350, 1'b1, 1300);
      queue_tick(1'b0, LOCK_ALL, 2047, 1'b1, 1048575, 1'b1, 2047);
      queue_tick(1'b0, LOCK_ALL, -400, 1'b1, 2500, 1'b1, 550);
      queue_tick(1'b0, LOCK_ALL, 0, 1'b1, 2500, 1'b1, 550);
      queue_tick(1'b0, LOCK_ALL, 1, 1'b1, 0, 1'b1, 0);
      queue_tick(1'b0, LOCK_ALL, 4, 1'b1, 4, 1'b1, 4);
      queue_tick(1'b0, LOCK_ALL, 5, 1'b1, 5, 1'b1, 5);
      queue_tick(1'b0, LOCK_ALL, 250, 1'b0, 2500, 1'b1, 550);
      queue_tick(1'b0, LOCK_ALL, 250, 1'b1, 2500, 1'b0, 550);
      queue_tick(1'b0, LOCK_ALL, 250, 1'b1, -1, 1'b1, 550);
      queue_tick(1'b0, LOCK_ALL, -2048, 1'b0, -1048576, 1'b0, 0);
      for (int s = 1; s < 8; s++) queue_tick(1'b0, 3'(s), 250, 1'b1, 2500, 1'b1, 550);
      queue_tick(1'b1, 3'd7, -5, 1'b0, -7, 1'b0, 2047);
      queue_tick(1'b0, LOCK_ALL, 275, 1'b1, 1495, 1'b1, 645);
      queue_tick(1'b0, LOCK_ALL, 274, 1'b1, 495, 1'b1, 495);
      queue_tick(1'b0, LOCK_ALL, 274, 1'b1, 495, 1'b1, 495);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 3) begin
            send_idle_pct = 52;
            recv_idle_pct = 11;
         end else if (ph == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (ph)
            0: apply_setting(1'b1, 1'b1, 1'b1, 1'b0, 3'd1, 3'd1, 3'd1);
            1: apply_setting(1'b1, 1'b1, 1'b1, 1'b0, 3'd7, 3'd7, 3'd7);
            2: apply_setting(1'b0, 1'b0, 1'b0, 1'b0, 3'd3, 3'd4, 3'd6);
            3: apply_setting(1'b1, 1'b1, 1'b1, 1'b1, 3'd2, 3'd5, 3'd2);
            4: apply_setting(1'b0, 1'b1, 1'b1, 1'b1, 3'd0, 3'd0, 3'd0);
            5: apply_setting(1'b1, 1'b0, 1'b1, 1'b0, 3'd4, 3'd2, 3'd3);
            6: apply_setting(1'b1, 1'b1, 1'b0, 1'b0, 3'd5, 3'd1, 3'd7);
            default: apply_setting(1'b1, 1'b1, 1'b1, 1'b0, 3'd2, 3'd5, 3'd2);
         endcase
         // long receiver hold-off while the sender keeps pushing
         if (ph == 6) hold_armed = 1'b1;
         queue_random_ticks(165);
         wait_drained();
      end

      if (tick_outcomes.size() != 0) flag_error("expected results left over");
      if (mismatches == 0)
         $display("three_sensor_category_debouncer verification clean");
      else
         $display("three_sensor_category_debouncer verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/tscd_pkg.sv
rtl/core/tscd_debounce.sv
rtl/core/three_sensor_category_debouncer.sv
dv/tb_top.sv
